[hw/rtl/aae_pkg.sv]
// shared types and constants for the adaptive arithmetic encoder
package aae_pkg;

  localparam int CODE_BITS_DEF   = 16;
  localparam int NUM_CHARS_DEF   = 256;
  localparam int PENDING_CAP_DEF = 480;

  // width of symbol and cumulative counts
  localparam int CNT_W = 14;
  localparam logic [CNT_W-1:0] COUNT_LIMIT_RST = 14'd16383;

  // per-item result buffer
  localparam int MAX_RES = 64;
  localparam int BUF_AW  = 6;

  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } sym_item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       run_last;
    logic       stream_end;
    logic       pending_overflow;
  } code_item_t;

endpackage

[hw/rtl/aae_ram.sv]
// generic single write port ram with registered read
module aae_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/aae_mdiv.sv]
// shared multiply then bit-serial divide unit: q = (a * b) / d
module aae_mdiv import aae_pkg::*; #(
  parameter int AW = CODE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [CNT_W-1:0] b,
  input  logic [CNT_W-1:0] d,
  output logic [AW-1:0]    q,
  output logic             done
);

  localparam int DW  = AW + CNT_W;
  localparam int CTW = $clog2(DW + 1);

  logic [DW-1:0]    prod;
  logic [DW-1:0]    dvd;
  logic [CNT_W-1:0] den;
  logic [CNT_W-1:0] rem;
  logic [CTW-1:0]   cnt;
  logic             busy;
  logic [CNT_W:0]   trial;
  logic             fits;

  assign prod  = a * b;
  assign trial = {rem, dvd[DW-1]};
  assign fits  = trial >= {1'b0, den};
  assign q     = dvd[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= prod;
        den  <= d;
        rem  <= '0;
        cnt  <= CTW'(DW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? CNT_W'(trial - {1'b0, den}) : trial[CNT_W-1:0];
        dvd <= {dvd[DW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/adaptive_arithmetic_encoder.sv]
// adaptive arithmetic encoder top level
//
// usage: one item at a time enters on the sym channel (valid/ready); cmd
// CMD_DATA codes data_byte, CMD_FINISH codes the end symbol and flushes.
// each item gives zero to 64 code bytes on the code channel; the last byte
// of an item carries run_last, the last byte of a finish item also carries
// stream_end, and every byte carries the sticky pending overflow flag as it
// stands after the item. the count limit register is written with limit_we.
// steps: a byte lookup, three count reads, two multiply/divide passes on
// the shared divider, then the renormalization steps with each pending bit
// sent, then the model update: halving when the total reaches the count
// limit, the rank search over equal counts, a swap and the increment of
// the cumulative entries, then the buffered bytes are drained.
// reset and every finish item start a clearing pass that reloads the
// model memories; sym_ready stays low meanwhile.
// a stalled receiver holds the output register; the next item is taken
// while the last byte still waits, but its bytes wait for the register.
module adaptive_arithmetic_encoder import aae_pkg::*; #(
  parameter int CODE_BITS   = CODE_BITS_DEF,
  parameter int NUM_CHARS   = NUM_CHARS_DEF,
  parameter int PENDING_CAP = PENDING_CAP_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sym_valid,
  output logic             sym_ready,
  input  sym_item_t        sym,
  output logic             code_valid,
  input  logic             code_ready,
  output code_item_t       code,
  input  logic             limit_we,
  input  logic [CNT_W-1:0] limit_wdata
);

  localparam int DEPTH = NUM_CHARS + 2;
  localparam int RW    = $clog2(DEPTH);
  localparam int BYW   = $clog2(NUM_CHARS);
  localparam int PW    = $clog2(PENDING_CAP + 1);
  localparam int ITW   = $clog2(CODE_BITS + 1);
  localparam int CB    = CODE_BITS;

  localparam logic [RW-1:0] NSYM     = RW'(NUM_CHARS + 1);
  localparam logic [RW-1:0] LAST_IDX = RW'(DEPTH - 1);
  localparam logic [CB-1:0] TOP_VAL  = {CB{1'b1}};
  localparam logic [CB-1:0] Q1       = CB'(1) << (CB - 2);
  localparam logic [CB-1:0] HALF_V   = CB'(1) << (CB - 1);
  localparam logic [CB-1:0] Q3       = CB'(3) << (CB - 2);
  localparam logic [PW-1:0] CAP      = PW'(PENDING_CAP);

  // sequencer states
  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_LOOK  = 5'd2;
  localparam logic [4:0] S_RD0   = 5'd3;
  localparam logic [4:0] S_RD1   = 5'd4;
  localparam logic [4:0] S_RD2   = 5'd5;
  localparam logic [4:0] S_RD3   = 5'd6;
  localparam logic [4:0] S_DIVH  = 5'd7;
  localparam logic [4:0] S_DIVL  = 5'd8;
  localparam logic [4:0] S_RN    = 5'd9;
  localparam logic [4:0] S_SB    = 5'd10;
  localparam logic [4:0] S_SP    = 5'd11;
  localparam logic [4:0] S_FIN   = 5'd12;
  localparam logic [4:0] S_FLUSH = 5'd13;
  localparam logic [4:0] S_AD    = 5'd14;
  localparam logic [4:0] S_HRD   = 5'd15;
  localparam logic [4:0] S_HWR   = 5'd16;
  localparam logic [4:0] S_FND   = 5'd17;
  localparam logic [4:0] S_FV    = 5'd18;
  localparam logic [4:0] S_FCHK  = 5'd19;
  localparam logic [4:0] S_FCMP  = 5'd20;
  localparam logic [4:0] S_SW0   = 5'd21;
  localparam logic [4:0] S_SW1   = 5'd22;
  localparam logic [4:0] S_SW2   = 5'd23;
  localparam logic [4:0] S_SW3   = 5'd24;
  localparam logic [4:0] S_INC   = 5'd25;
  localparam logic [4:0] S_CRD   = 5'd26;
  localparam logic [4:0] S_CWR   = 5'd27;
  localparam logic [4:0] S_DRD   = 5'd28;
  localparam logic [4:0] S_DLD   = 5'd29;

  logic [4:0] state;

  // coder state
  logic [CB-1:0]    low, high, hq;
  logic [PW-1:0]    pending;
  logic [7:0]       bsr;
  logic [2:0]       bf;
  logic             ovf, flag;
  logic [CNT_W-1:0] count_limit;

  // item and model walk registers
  logic             fin, fin_send, bit_val;
  logic [RW-1:0]    s, i, j, k, ca;
  logic [CNT_W-1:0] total, c_hi, c_lo, val, acc;
  logic [7:0]       ci;
  logic [ITW-1:0]   it;
  logic [BUF_AW:0]  cnt;
  logic [BUF_AW-1:0] rk;

  // memory ports
  logic             sc_we, sc_re, cum_we, cum_re, r2b_we, r2b_re, b2r_we, b2r_re;
  logic [RW-1:0]    sc_waddr, sc_raddr, cum_waddr, cum_raddr, r2b_waddr, r2b_raddr;
  logic [BYW-1:0]   b2r_waddr, b2r_raddr;
  logic [CNT_W-1:0] sc_wdata, sc_rdata, cum_wdata, cum_rdata;
  logic [7:0]       r2b_wdata, r2b_rdata;
  logic [RW-1:0]    b2r_wdata, b2r_rdata;
  logic             buf_we, buf_re;
  logic [BUF_AW-1:0] buf_waddr, buf_raddr;
  logic [7:0]       buf_wdata, buf_rdata;

  // divider
  logic             div_start, div_done;
  logic [CNT_W-1:0] div_b, div_d;
  logic [CB-1:0]    div_q;

  // bit packing and pending helpers
  logic             put_en, put_b, pinc, flush_emit, emit;
  logic [7:0]       bsr_next, flush_byte;
  logic [PW-1:0]    pend_next;
  logic [CNT_W:0]   hsum;
  logic [CNT_W-1:0] hv;
  logic             accept, load_out, last_out;

  assign sym_ready = (state == S_IDLE);
  assign accept    = sym_valid && sym_ready;
  assign div_d     = (total == '0) ? CNT_W'(1) : total;
  assign hsum      = {1'b0, sc_rdata} + 1'b1;
  assign hv        = hsum[CNT_W:1];
  assign bsr_next  = {put_b, bsr[7:1]};
  assign pend_next = (pending < CAP) ? pending + 1'b1 : pending;
  assign flush_byte = bsr >> (4'd8 - {1'b0, bf});
  assign flush_emit = (state == S_FLUSH) && (bf != 3'd0);
  assign emit       = (put_en && (bf == 3'd7)) || flush_emit;
  assign buf_we     = emit && !cnt[BUF_AW];
  assign buf_waddr  = cnt[BUF_AW-1:0];
  assign buf_wdata  = flush_emit ? flush_byte : bsr_next;
  assign last_out   = ({1'b0, rk} == cnt - 1'b1);
  assign load_out   = (state == S_DLD) && (!code_valid || code_ready);

  always_comb begin
    put_en = 1'b0;
    put_b  = 1'b0;
    pinc   = 1'b0;
    case (state)
      S_SB: begin
        put_en = 1'b1;
        put_b  = bit_val;
      end
      S_SP: begin
        put_en = (pending != '0);
        put_b  = !bit_val;
      end
      S_FIN: pinc = 1'b1;
      S_RN: begin
        pinc = (it != ITW'(CB)) && (high >= HALF_V) && (low < HALF_V) &&
               (low >= Q1) && (high < Q3);
      end
      default: ;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_b     = c_hi;
    case (state)
      S_RD3: div_start = 1'b1;
      S_DIVH: begin
        div_start = div_done;
        div_b     = c_lo;
      end
      default: ;
    endcase
  end

  // memory address and write steering
  always_comb begin
    sc_we = 1'b0;  sc_waddr = '0;  sc_wdata = '0;  sc_re = 1'b0;  sc_raddr = '0;
    cum_we = 1'b0; cum_waddr = '0; cum_wdata = '0; cum_re = 1'b0; cum_raddr = '0;
    r2b_we = 1'b0; r2b_waddr = '0; r2b_wdata = '0; r2b_re = 1'b0; r2b_raddr = '0;
    b2r_we = 1'b0; b2r_waddr = '0; b2r_wdata = '0; b2r_re = 1'b0; b2r_raddr = '0;
    buf_re = 1'b0; buf_raddr = '0;
    case (state)
      S_CLEAR: begin
        sc_we     = 1'b1;
        sc_waddr  = ca;
        sc_wdata  = (ca == '0) ? '0 : CNT_W'(1);
        cum_we    = 1'b1;
        cum_waddr = ca;
        cum_wdata = CNT_W'(NSYM - ca);
        r2b_we    = 1'b1;
        r2b_waddr = ca;
        r2b_wdata = (ca == '0) ? 8'd0 : 8'(ca - 1'b1);
        b2r_we    = (ca < RW'(NUM_CHARS));
        b2r_waddr = ca[BYW-1:0];
        b2r_wdata = ca + 1'b1;
      end
      S_IDLE: begin
        b2r_re    = sym_valid;
        b2r_raddr = sym.data_byte[BYW-1:0];
      end
      S_LOOK, S_RD0: cum_re = 1'b1;
      S_RD1: begin
        cum_re    = 1'b1;
        cum_raddr = s - 1'b1;
      end
      S_RD2: begin
        cum_re    = 1'b1;
        cum_raddr = s;
      end
      S_HRD: begin
        sc_re    = 1'b1;
        sc_raddr = k;
      end
      S_HWR: begin
        sc_we     = 1'b1;
        sc_waddr  = k;
        sc_wdata  = hv;
        cum_we    = 1'b1;
        cum_waddr = k;
        cum_wdata = acc;
      end
      S_FND: begin
        sc_re    = 1'b1;
        sc_raddr = s;
      end
      S_FCHK: begin
        sc_re    = (i > RW'(1));
        sc_raddr = i - 1'b1;
      end
      S_SW0: begin
        r2b_re    = 1'b1;
        r2b_raddr = i;
      end
      S_SW1: begin
        r2b_re    = 1'b1;
        r2b_raddr = s;
      end
      S_SW2: begin
        r2b_we    = 1'b1;
        r2b_waddr = i;
        r2b_wdata = r2b_rdata;
        b2r_we    = 1'b1;
        b2r_waddr = r2b_rdata[BYW-1:0];
        b2r_wdata = i;
      end
      S_SW3: begin
        r2b_we    = 1'b1;
        r2b_waddr = s;
        r2b_wdata = ci;
        b2r_we    = 1'b1;
        b2r_waddr = ci[BYW-1:0];
        b2r_wdata = s;
      end
      S_INC: begin
        sc_we    = 1'b1;
        sc_waddr = i;
        sc_wdata = val + 1'b1;
      end
      S_CRD: begin
        cum_re    = (j != '0);
        cum_raddr = j - 1'b1;
      end
      S_CWR: begin
        cum_we    = 1'b1;
        cum_waddr = j;
        cum_wdata = cum_rdata + 1'b1;
      end
      S_DRD: buf_re = (cnt != '0);
      S_DLD: begin
        buf_re    = load_out && !last_out;
        buf_raddr = rk + 1'b1;
      end
      default: ;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit <= COUNT_LIMIT_RST;
    end else if (limit_we) begin
      count_limit <= limit_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (load_out) begin
      code_valid <= 1'b1;
    end else if (code_ready) begin
      code_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      code.code_byte        <= buf_rdata;
      code.run_last         <= last_out;
      code.stream_end       <= fin && last_out;
      code.pending_overflow <= flag;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      ca       <= '0;
      low      <= '0;
      high     <= TOP_VAL;
      pending  <= '0;
      bsr      <= '0;
      bf       <= '0;
      ovf      <= 1'b0;
      flag     <= 1'b0;
      cnt      <= '0;
      fin      <= 1'b0;
      fin_send <= 1'b0;
    end else begin
      // bit packer, shared by all sends
      if (put_en) begin
        bsr <= bsr_next;
        bf  <= bf + 1'b1;
      end
      if (emit && !cnt[BUF_AW]) begin
        cnt <= cnt + 1'b1;
      end
      if (pinc) begin
        pending <= pend_next;
        if (pend_next >= CAP) begin
          ovf <= 1'b1;
        end
      end

      case (state)
        S_CLEAR: begin
          ca <= ca + 1'b1;
          if (ca == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cnt      <= '0;
            fin      <= sym.cmd;
            fin_send <= 1'b0;
            if (sym.cmd == CMD_FINISH) begin
              s     <= NSYM;
              state <= S_RD0;
            end else if ({1'b0, sym.data_byte} < 9'(NUM_CHARS)) begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          s     <= b2r_rdata;
          state <= S_RD1;
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          total <= cum_rdata;
          state <= S_RD2;
        end
        S_RD2: begin
          c_hi  <= cum_rdata;
          state <= S_RD3;
        end
        S_RD3: begin
          c_lo  <= cum_rdata;
          state <= S_DIVH;
        end
        S_DIVH: begin
          if (div_done) begin
            hq    <= div_q;
            state <= S_DIVL;
          end
        end
        S_DIVL: begin
          if (div_done) begin
            high  <= low + hq;
            low   <= low + div_q;
            it    <= '0;
            state <= S_RN;
          end
        end
        // renormalization: one scaling step per visit
        S_RN: begin
          if (it == ITW'(CB)) begin
            state <= fin ? S_FIN : S_AD;
          end else if (high < HALF_V) begin
            bit_val <= 1'b0;
            low     <= {low[CB-2:0], 1'b0};
            high    <= {high[CB-2:0], 1'b0};
            it      <= it + 1'b1;
            state   <= S_SB;
          end else if (low >= HALF_V) begin
            bit_val <= 1'b1;
            low     <= {low[CB-2:0], 1'b0};
            high    <= {high[CB-2:0], 1'b0};
            it      <= it + 1'b1;
            state   <= S_SB;
          end else if (low >= Q1 && high < Q3) begin
            low  <= (low - Q1) << 1;
            high <= (high - Q1) << 1;
            it   <= it + 1'b1;
          end else begin
            state <= fin ? S_FIN : S_AD;
          end
        end
        S_SB: state <= S_SP;
        S_SP: begin
          if (pending != '0) begin
            pending <= pending - 1'b1;
          end else begin
            state <= fin_send ? S_FLUSH : S_RN;
          end
        end
        S_FIN: begin
          bit_val  <= (low >= Q1);
          fin_send <= 1'b1;
          state    <= S_SB;
        end
        S_FLUSH: begin
          bf    <= '0;
          state <= S_DRD;
        end
        // model update: once the total reaches the count limit, a halving sweep from the top entry down
        S_AD: begin
          if (total >= count_limit) begin
            k     <= NSYM;
            acc   <= '0;
            state <= S_HRD;
          end else begin
            state <= S_FND;
          end
        end
        S_HRD: state <= S_HWR;
        S_HWR: begin
          acc <= acc + hv;
          k   <= k - 1'b1;
          state <= (k == '0) ? S_FND : S_HRD;
        end
        S_FND: begin
          i     <= s;
          state <= S_FV;
        end
        S_FV: begin
          val   <= sc_rdata;
          state <= S_FCHK;
        end
        // walk down the run of equal counts
        S_FCHK: begin
          if (i > RW'(1)) begin
            state <= S_FCMP;
          end else begin
            state <= (i < s) ? S_SW0 : S_INC;
          end
        end
        S_FCMP: begin
          if (sc_rdata == val) begin
            i     <= i - 1'b1;
            state <= S_FCHK;
          end else begin
            state <= (i < s) ? S_SW0 : S_INC;
          end
        end
        S_SW0: state <= S_SW1;
        S_SW1: begin
          ci    <= r2b_rdata;
          state <= S_SW2;
        end
        S_SW2: state <= S_SW3;
        S_SW3: state <= S_INC;
        S_INC: begin
          j     <= i;
          state <= S_CRD;
        end
        S_CRD: begin
          if (j == '0) begin
            state <= S_DRD;
          end else begin
            j     <= j - 1'b1;
            state <= S_CWR;
          end
        end
        S_CWR: state <= S_CRD;
        // hand the buffered bytes to the output register
        S_DRD: begin
          flag <= ovf;
          rk   <= '0;
          if (fin) begin
            low     <= '0;
            high    <= TOP_VAL;
            pending <= '0;
            bsr     <= '0;
            ovf     <= 1'b0;
          end
          if (cnt != '0) begin
            state <= S_DLD;
          end else if (fin) begin
            ca    <= '0;
            state <= S_CLEAR;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DLD: begin
          if (load_out) begin
            if (last_out) begin
              ca    <= '0;
              state <= fin ? S_CLEAR : S_IDLE;
            end else begin
              rk <= rk + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  aae_mdiv #(.AW(CB)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (high - low),
    .b     (div_b),
    .d     (div_d),
    .q     (div_q),
    .done  (div_done)
  );

  aae_ram #(.W(CNT_W), .D(DEPTH)) u_sc (
    .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
    .re(sc_re), .raddr(sc_raddr), .rdata(sc_rdata)
  );

  aae_ram #(.W(CNT_W), .D(DEPTH)) u_cum (
    .clk(clk), .we(cum_we), .waddr(cum_waddr), .wdata(cum_wdata),
    .re(cum_re), .raddr(cum_raddr), .rdata(cum_rdata)
  );

  aae_ram #(.W(8), .D(DEPTH)) u_r2b (
    .clk(clk), .we(r2b_we), .waddr(r2b_waddr), .wdata(r2b_wdata),
    .re(r2b_re), .raddr(r2b_raddr), .rdata(r2b_rdata)
  );

  aae_ram #(.W(RW), .D(NUM_CHARS)) u_b2r (
    .clk(clk), .we(b2r_we), .waddr(b2r_waddr), .wdata(b2r_wdata),
    .re(b2r_re), .raddr(b2r_raddr), .rdata(b2r_rdata)
  );

  aae_ram #(.W(8), .D(MAX_RES)) u_buf (
    .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
    .re(buf_re), .raddr(buf_raddr), .rdata(buf_rdata)
  );

endmodule

[hw/rtl/aae_chk.sv]
// port-level checker for the encoder, bound to the top level
module aae_chk import aae_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       sym_valid,
  input logic       sym_ready,
  input sym_item_t  sym,
  input logic       code_valid,
  input logic       code_ready,
  input code_item_t code
);

  // end of stream is always the last byte of its item
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    code_valid |-> (!code.stream_end || code.run_last))
    else $error("stream_end without run_last");

  // a finish transfer starts a busy period
  a_fin_busy: assert property (@(posedge clk) disable iff (rst)
    sym_valid && sym_ready && sym.cmd == CMD_FINISH |=> !sym_ready)
    else $error("ready after finish transfer");

  // model clearing follows reset
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !sym_ready)
    else $error("ready right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    code_valid && !code_ready |=> code_valid && $stable(code))
    else $error("stalled result changed");

endmodule

bind adaptive_arithmetic_encoder aae_chk u_chk (.*);

[dv/adaptive_arithmetic_encoder_tb.sv]
// self-checking testbench for the adaptive arithmetic encoder top level
module adaptive_arithmetic_encoder_tb import aae_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // coder constants for CODE_BITS = 16
  localparam int unsigned TOP_V  = 32'h0000_FFFF;
  localparam int unsigned QTR_V  = 32'h0000_4000;
  localparam int unsigned HALF_V = 32'h0000_8000;
  localparam int unsigned Q3_V   = 32'h0000_C000;
  localparam int unsigned CAP_V  = 480;
  localparam int unsigned NSYM   = 257;
  localparam int unsigned END_RANK = 257;
  // idle time before a register write, covers items that give no byte
  localparam int DRAIN_CYC = 2500;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             sym_valid = 1'b0;
  logic             sym_ready;
  sym_item_t        sym = '0;
  logic             code_valid;
  logic             code_ready = 1'b0;
  code_item_t       code;
  logic             limit_we = 1'b0;
  logic [CNT_W-1:0] limit_wdata = COUNT_LIMIT_RST;

  adaptive_arithmetic_encoder i_dut (
    .clk         (clk),
    .rst         (rst),
    .sym_valid   (sym_valid),
    .sym_ready   (sym_ready),
    .sym         (sym),
    .code_valid  (code_valid),
    .code_ready  (code_ready),
    .code        (code),
    .limit_we    (limit_we),
    .limit_wdata (limit_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------
  // encoder model: interval coder plus frequency-ranked symbol table
  // ---------------------------------------------------------------
  int unsigned lim_m;
  int unsigned lo_m, hi_m, pend_m, fill_m;
  bit [7:0]    shift_m;
  bit          ovf_m;
  int unsigned freq_m[258];
  int unsigned cum_m[258];
  int unsigned rank_of[256];
  int unsigned byte_of[258];
  bit [7:0]    item_bytes[$];   // bytes produced by the item in progress

  code_item_t  code_exp_q[$];   // expected code bytes, oldest first
  sym_item_t   sym_pend_q[$];   // items waiting to be driven
  int          err_cnt = 0;
  bit          quiet = 1'b0;    // no idling on either side

  function automatic void model_clear();
    lo_m = 0; hi_m = TOP_V; pend_m = 0; shift_m = '0; fill_m = 0; ovf_m = 1'b0;
    for (int i = 0; i < 256; i++) rank_of[i] = i + 1;
    for (int i = 0; i < 258; i++) begin
      byte_of[i] = (i > 0) ? (i - 1) & 8'hFF : 0;
      freq_m[i]  = 1;
      cum_m[i]   = (i <= NSYM) ? NSYM - i : 0;
    end
    freq_m[0] = 0;
  endfunction

  function automatic void shift_in(int unsigned b);
    shift_m = {b[0], shift_m[7:1]};
    fill_m++;
    if (fill_m == 8) begin
      if (item_bytes.size() < MAX_RES) item_bytes = {item_bytes, shift_m};
      fill_m = 0;
    end
  endfunction

  function automatic void send_bit(int unsigned b);
    shift_in(b);
    while (pend_m > 0) begin
      shift_in(b ? 0 : 1);
      pend_m--;
    end
  endfunction

  function automatic void bump_pending();
    if (pend_m < CAP_V) pend_m++;
    if (pend_m >= CAP_V) ovf_m = 1'b1;
  endfunction

  function automatic void narrow(int unsigned s);
    longint unsigned tot, rng;
    int unsigned base;
    tot  = cum_m[0];
    rng  = hi_m - lo_m;
    base = lo_m;
    if (tot == 0) tot = 1;
    hi_m = (base + (rng * cum_m[s-1]) / tot) & TOP_V;
    lo_m = (base + (rng * cum_m[s]) / tot) & TOP_V;
    for (int it = 0; it < 16; it++) begin
      if (hi_m < HALF_V) begin
        send_bit(0);
      end else if (lo_m >= HALF_V) begin
        send_bit(1);
        lo_m -= HALF_V;
        hi_m -= HALF_V;
      end else if (lo_m >= QTR_V && hi_m < Q3_V) begin
        bump_pending();
        lo_m -= QTR_V;
        hi_m -= QTR_V;
      end else begin
        break;
      end
      lo_m = (2 * lo_m) & TOP_V;
      hi_m = (2 * hi_m) & TOP_V;
    end
  endfunction

  function automatic void adapt(int unsigned s);
    int unsigned i, acc, ci, cs;
    if (cum_m[0] >= lim_m) begin
      acc = 0;
      for (int k = NSYM; k >= 0; k--) begin
        freq_m[k] = (freq_m[k] + 1) / 2;
        cum_m[k]  = acc;
        acc += freq_m[k];
      end
    end
    i = s;
    while (i > 1 && freq_m[i] == freq_m[i-1]) i--;
    if (i < s) begin
      ci = byte_of[i] & 8'hFF;
      cs = byte_of[s] & 8'hFF;
      byte_of[i] = cs;
      byte_of[s] = ci;
      rank_of[ci] = s;
      rank_of[cs] = i;
    end
    freq_m[i] = (freq_m[i] + 1) & 14'h3FFF;
    while (i > 0) begin
      i--;
      cum_m[i] = (cum_m[i] + 1) & 14'h3FFF;
    end
  endfunction

  // code one accepted item and queue the bytes it should give
  function automatic void encode_item(sym_item_t it);
    code_item_t c;
    bit flag;
    item_bytes.delete();
    if (it.cmd == CMD_DATA) begin
      narrow(rank_of[it.data_byte]);
      adapt(rank_of[it.data_byte]);
      flag = ovf_m;
    end else begin
      narrow(END_RANK);
      bump_pending();
      send_bit(lo_m < QTR_V ? 0 : 1);
      // partial byte is right-aligned, an empty register adds nothing
      if (fill_m > 0 && fill_m < 8 && item_bytes.size() < MAX_RES)
        item_bytes = {item_bytes, 8'(shift_m >> (8 - fill_m))};
      fill_m = 0;
      flag = ovf_m;
      model_clear();
    end
    foreach (item_bytes[k]) begin
      c.code_byte        = item_bytes[k];
      c.run_last         = (k == item_bytes.size() - 1);
      c.stream_end       = c.run_last && (it.cmd == CMD_FINISH);
      c.pending_overflow = flag;
      code_exp_q = {code_exp_q, c};
    end
  endfunction

  // ---------------------------------------------------------------
  // sender: drives items from the pending queue, bursts of idle cycles
  // ---------------------------------------------------------------
  int gap_cnt = 0;
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      sym_valid <= 1'b0;
    end else begin
      if (sym_valid && sym_ready) encode_item(sym);
      if (!(sym_valid && !sym_ready)) begin
        nv = 1'b0;
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (sym_pend_q.size() > 0) begin
          sym <= sym_pend_q.pop_front();
          nv = 1'b1;
          if (!quiet && $urandom_range(3) == 0) gap_cnt = $urandom_range(13, 1);
        end
        sym_valid <= nv;
      end
    end
  end

  // ---------------------------------------------------------------
  // receiver: random stalls, compare each transfer with the oldest byte
  // ---------------------------------------------------------------
  int stall_cnt = 0;
  always @(posedge clk) begin
    code_item_t e;
    if (rst) begin
      code_ready <= 1'b0;
    end else begin
      if (code_valid && code_ready) begin
        if (code_exp_q.size() == 0) begin
          $error("unexpected code byte %02h", code.code_byte);
          err_cnt++;
        end else begin
          e = code_exp_q.pop_front();
          if (code.code_byte !== e.code_byte) begin
            $error("code_byte exp %02h got %02h", e.code_byte, code.code_byte);
            err_cnt++;
          end
          if (code.run_last !== e.run_last) begin
            $error("run_last exp %0b got %0b", e.run_last, code.run_last);
            err_cnt++;
          end
          if (code.stream_end !== e.stream_end) begin
            $error("stream_end exp %0b got %0b", e.stream_end, code.stream_end);
            err_cnt++;
          end
          if (code.pending_overflow !== e.pending_overflow) begin
            $error("pending_overflow exp %0b got %0b", e.pending_overflow,
                   code.pending_overflow);
            err_cnt++;
          end
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        code_ready <= 1'b0;
      end else if (!quiet && $urandom_range(7) == 0) begin
        stall_cnt = $urandom_range(12, 0);
        code_ready <= 1'b0;
      end else begin
        code_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------
  // phase control
  // ---------------------------------------------------------------
  task automatic push_item(logic cmd, logic [7:0] b);
    sym_item_t it;
    it.cmd = cmd;
    it.data_byte = b;
    sym_pend_q = {sym_pend_q, it};
  endtask

  // the test holds off until every transfer in flight has come back
  task automatic drain();
    while (sym_pend_q.size() > 0 || sym_valid || code_exp_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_limit(int unsigned v);
    limit_we    <= 1'b1;
    limit_wdata <= v[CNT_W-1:0];
    @(posedge clk);
    limit_we <= 1'b0;
    lim_m = v;
  endtask

  // random streams: mostly data from a narrow alphabet so ranks move,
  // some full-range bytes, and a finish closing each stream
  task automatic random_streams(int n);
    int cnt, len;
    logic [7:0] base;
    cnt = 0;
    while (cnt < n) begin
      len  = $urandom_range(30, 1);
      base = 8'($urandom);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(3) == 0) push_item(CMD_DATA, 8'($urandom));
        else push_item(CMD_DATA, 8'(base ^ $urandom_range(3)));
      end
      push_item(CMD_FINISH, 8'($urandom));
      cnt += len + 1;
    end
  endtask

  initial begin
    lim_m = COUNT_LIMIT_RST;
    model_clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, repeats that reorder ranks, empty stream
    push_item(CMD_DATA, 8'h00);
    push_item(CMD_DATA, 8'hFF);
    push_item(CMD_DATA, 8'h80);
    push_item(CMD_DATA, 8'h7F);
    push_item(CMD_DATA, 8'hAA);
    push_item(CMD_DATA, 8'h55);
    for (int k = 0; k < 6; k++) push_item(CMD_DATA, 8'h41);
    push_item(CMD_DATA, 8'hFF);
    push_item(CMD_FINISH, 8'hFF);
    push_item(CMD_FINISH, 8'h00);
    drain();

    // lowest limit: halving on almost every item
    write_limit(258);
    for (int k = 0; k < 8; k++) push_item(CMD_DATA, 8'h10);
    push_item(CMD_FINISH, 8'h00);
    random_streams(38);
    drain();

    write_limit(16383);
    random_streams(38);
    drain();

    // mid-range limit, last part runs without idling
    write_limit($urandom_range(16000, 259));
    quiet = 1'b1;
    random_streams(38);
    while (sym_pend_q.size() > 0 || sym_valid || code_exp_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (err_cnt == 0 && code_exp_q.size() == 0) begin
      $display("** adaptive_arithmetic_encoder: PASSED **");
    end else begin
      $display("** adaptive_arithmetic_encoder: FAILED **");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("** adaptive_arithmetic_encoder: FAILED **");
    $finish;
  end

endmodule
